@@ rtl/core/sorted_key_value_table_core_macros.svh @@
// Assertion helpers for the sorted key/value table core
`ifndef SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define SKVT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("skvt assertion failed");

// Next-cycle implication, disabled while reset is active
`define SKVT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("skvt assertion failed");

`endif

@@ rtl/core/skvt_pkg.sv @@
package skvt_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    // Default table depth
    localparam int DEPTH_DEF = 64;

    // Request kinds
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;     // latch compare flags against the request key
        logic ins_sel;    // hit marks the insert slot instead of the first match
        logic wr_insert;  // shift larger entries up and drop in the new entry
        logic wr_remove;  // shift entries at and past the first match down
    } cell_cmd_t;

endpackage

@@ rtl/core/skvt_cell.sv @@
module skvt_cell
    import skvt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_cmd_t        cmd,
    input  logic [KEY_W-1:0] req_key,
    input  logic [VAL_W-1:0] req_value,
    input  logic             occ,
    input  logic             at_count,
    input  logic             left_gt,
    input  logic             left_eq,
    input  logic [KEY_W-1:0] left_key,
    input  logic [VAL_W-1:0] left_value,
    input  logic [KEY_W-1:0] right_key,
    input  logic [VAL_W-1:0] right_value,
    output logic             gt,
    output logic             eq,
    output logic             hit,
    output logic [KEY_W-1:0] key_q,
    output logic [VAL_W-1:0] value_q
);

    logic             gt_reg;
    logic             eq_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             sel_new;

    // Latch compare flags; an empty cell never compares greater or equal
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (cmd.cmp_en) begin
            gt_reg <= occ && (key_reg > req_key);
            eq_reg <= occ && (key_reg == req_key);
        end
    end

    // Insert slot: first cell past all keys not greater than the request
    assign sel_new = !left_gt && (gt_reg || at_count);

    // Mark the insert slot or the first equal entry
    assign hit = cmd.ins_sel ? sel_new : (eq_reg && !left_eq);

    // Shift entries: up from the left on insert, down from the right on remove
    always_ff @(posedge aclk) begin
        if (cmd.wr_insert) begin
            if (left_gt) begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end else if (sel_new) begin
                key_reg   <= req_key;
                value_reg <= req_value;
            end
        end else if (cmd.wr_remove) begin
            if (gt_reg || eq_reg) begin
                key_reg   <= right_key;
                value_reg <= right_value;
            end
        end
    end

    assign gt      = gt_reg;
    assign eq      = eq_reg;
    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

@@ rtl/core/sorted_key_value_table_core.sv @@
// Sorted key/value table built as a chain of DEPTH cells, one entry per cell,
// kept in ascending unsigned key order. An accepted request first compares
// the request key in every cell at once, held off while the output register
// still holds an untaken beat; then it shifts the chain by a single place
// and encodes the hit cell's index and value into the output register. A new
// request is taken once the previous one has reached the output register, so
// the block takes no new request before it is through with the last one.
// The entry storage needs no clearing after reset; the fill count, sequencer
// state, output valid and cell compare flags reset.
`include "sorted_key_value_table_core_macros.svh"

module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [KEY_W-1:0]     s_key,
    input  logic [VAL_W-1:0]     s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [VAL_W-1:0]     m_found_value,
    output logic [POS_W-1:0]     m_position,
    output logic [CNT_OUT_W-1:0] m_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [VAL_W-1:0]    fval_reg;
    logic [VAL_W-1:0]    fval_next;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;

    logic                out_free;
    logic                found;
    logic                is_full;
    cell_cmd_t           cmd;

    logic [DEPTH-1:0]    occ_vec;
    logic [DEPTH-1:0]    at_cnt_vec;
    logic [DEPTH-1:0]    gt_vec;
    logic [DEPTH-1:0]    eq_vec;
    logic [DEPTH-1:0]    hit_vec;
    logic [KEY_W-1:0]    key_arr [DEPTH];
    logic [VAL_W-1:0]    val_arr [DEPTH];
    logic [IDX_W-1:0]    red_idx;
    logic [VAL_W-1:0]    red_val;

    logic [POS_W+IDX_W-1:0]     pos_ext;
    logic [CNT_OUT_W+CNT_W-1:0] cnt_ext;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign found    = |eq_vec;
    assign is_full  = (count_reg == CNT_FULL);

    // Sequence: idle, compare, then shift and load the output register
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CMP;
            end
            S_CMP: begin
                if (out_free) state_next = S_APPLY;
            end
            S_APPLY: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the request beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    // Drive the broadcast controls
    always_comb begin
        cmd.cmp_en    = (state_reg == S_CMP) && out_free;
        cmd.ins_sel   = (op_reg == OP_INSERT);
        cmd.wr_insert = (state_reg == S_APPLY) && (op_reg == OP_INSERT) && !is_full;
        cmd.wr_remove = (state_reg == S_APPLY) && (op_reg == OP_REMOVE) && found;
    end

    // Per-cell occupancy from the fill count
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ_vec[i]    = (CNT_W'(i) < count_reg);
            at_cnt_vec[i] = (CNT_W'(i) == count_reg);
        end
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             l_gt;
        logic             l_eq;
        logic [KEY_W-1:0] l_key;
        logic [VAL_W-1:0] l_val;
        logic [KEY_W-1:0] r_key;
        logic [VAL_W-1:0] r_val;

        if (g == 0) begin : g_first
            assign l_gt  = 1'b0;
            assign l_eq  = 1'b0;
            assign l_key = '0;
            assign l_val = '0;
        end else begin : g_mid_l
            assign l_gt  = gt_vec[g-1];
            assign l_eq  = eq_vec[g-1];
            assign l_key = key_arr[g-1];
            assign l_val = val_arr[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign r_key = key_arr[g];
            assign r_val = val_arr[g];
        end else begin : g_mid_r
            assign r_key = key_arr[g+1];
            assign r_val = val_arr[g+1];
        end

        skvt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .req_key     (key_reg),
            .req_value   (value_reg),
            .occ         (occ_vec[g]),
            .at_count    (at_cnt_vec[g]),
            .left_gt     (l_gt),
            .left_eq     (l_eq),
            .left_key    (l_key),
            .left_value  (l_val),
            .right_key   (r_key),
            .right_value (r_val),
            .gt          (gt_vec[g]),
            .eq          (eq_vec[g]),
            .hit         (hit_vec[g]),
            .key_q       (key_arr[g]),
            .value_q     (val_arr[g])
        );
    end

    // Encode the one-hot hit into its index and value
    always_comb begin
        red_idx = '0;
        red_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            red_idx = red_idx | (hit_vec[i] ? IDX_W'(i) : '0);
            red_val = red_val | (hit_vec[i] ? val_arr[i] : '0);
        end
    end

    // Form the result and the new fill count
    always_comb begin
        status_next = ST_OK;
        fval_next   = '0;
        pos_next    = '0;
        count_next  = count_reg;
        case (op_reg)
            OP_INSERT: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    pos_next   = red_idx;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (found) begin
                    pos_next  = red_idx;
                    fval_next = red_val;
                end else begin
                    status_next = ST_MISSING;
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    pos_next   = red_idx;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_MISSING;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // Advance the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (state_reg == S_APPLY) begin
            count_reg <= count_next;
        end
    end

    // Load the output register; drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_APPLY) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_APPLY) begin
            status_reg <= status_next;
            fval_reg   <= fval_next;
            pos_reg    <= pos_next;
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, pos_reg};
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_reg};

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_value = fval_reg;
    assign m_position    = pos_ext[POS_W-1:0];
    assign m_entry_count = cnt_ext[CNT_OUT_W-1:0];

    // Fill count stays within the table
    `SKVT_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)

    // A result appears only right after the shift step
    `SKVT_ASSERT_SAME(a_valid_src, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == S_APPLY))

    // At most one cell claims the hit
    `SKVT_ASSERT_SAME(a_hit_onehot, aclk, aresetn, state_reg == S_APPLY, $onehot0(hit_vec))

    // Insert into a full table reports full and keeps the count
    `SKVT_ASSERT_NEXT(a_full_ins, aclk, aresetn,
        (state_reg == S_APPLY) && (op_reg == OP_INSERT) && is_full,
        (m_status == ST_FULL) && (count_reg == CNT_FULL))

    // The output register never loads over a beat still waiting
    `SKVT_ASSERT_SAME(a_no_overrun, aclk, aresetn, state_reg == S_APPLY,
        !m_valid_reg || $past(m_ready))

endmodule

@@ tb/sv/sorted_key_value_table_core_tb.sv @@
`timescale 1ns / 100ps

module sorted_key_value_table_core_tb
    import skvt_pkg::*;
();

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int POOL_SIZE    = 20;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_DELAY   = 150;
    localparam int HOLD_LEN     = 400;

    // Op code the block must treat as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [VAL_W-1:0]     found_value;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] entry_count;
    } table_reply_t;

    // Mirror of the sorted table plus the replies still owed by the block
    class table_mirror;
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        logic [VAL_W-1:0] vals [TABLE_DEPTH];
        int               count;
        table_reply_t     awaited [$];
        int               errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void apply_request(input logic [OP_W-1:0] op,
                                    input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] value);
            table_reply_t r;
            int           i;
            int           hit;
            r.status      = ST_OK;
            r.found_value = '0;
            r.position    = '0;
            // locate the first equal key, count when absent
            hit = count;
            for (i = count - 1; i >= 0; i--) begin
                if (keys[i] == key) hit = i;
            end
            case (op)
                OP_INSERT: begin
                    if (count >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // shift larger keys up, land after equal keys
                        i = count;
                        while (i > 0 && keys[i-1] > key) begin
                            keys[i] = keys[i-1];
                            vals[i] = vals[i-1];
                            i--;
                        end
                        keys[i]    = key;
                        vals[i]    = value;
                        count++;
                        r.position = POS_W'(i);
                    end
                end
                OP_FIND: begin
                    if (hit < count) begin
                        r.found_value = vals[hit];
                        r.position    = POS_W'(hit);
                    end else begin
                        r.status = ST_MISSING;
                    end
                end
                OP_REMOVE: begin
                    if (hit < count) begin
                        r.position = POS_W'(hit);
                        for (i = hit; i + 1 < count; i++) begin
                            keys[i] = keys[i+1];
                            vals[i] = vals[i+1];
                        end
                        count--;
                    end else begin
                        r.status = ST_MISSING;
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = CNT_OUT_W'(count);
            awaited.push_back(r);
        endfunction

        // Compare one result beat against the oldest queued reply
        function void check_reply(input table_reply_t got);
            table_reply_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d position %0d count %0d",
                         $time, got.status, got.position, got.entry_count);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.found_value !== want.found_value) begin
                $display("%0t: found_value expected %h actual %h",
                         $time, want.found_value, got.found_value);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op          = OP_INSERT;
    logic [KEY_W-1:0]     s_key         = '0;
    logic [VAL_W-1:0]     s_value       = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [VAL_W-1:0]     m_found_value;
    logic [POS_W-1:0]     m_position;
    logic [CNT_OUT_W-1:0] m_entry_count;

    table_mirror mirror;
    bit          random_phase = 1'b0;
    int          cycle_count  = 0;

    sorted_key_value_table_core #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_position    (m_position),
        .m_entry_count (m_entry_count)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // End the run if it never drains
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sorted_key_value_table_core verification failed");
        $finish;
    end

    // Offer one request beat and hold it until accepted
    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value);
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        mirror.apply_request(op, key, value);
    endtask

    // Drop valid for a number of cycles; zero keeps the stream back to back
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Result side: check accepted beats, stall on its own pattern
    initial begin : reply_sink
        table_reply_t got;
        int           ready_pct;
        int           pattern_left;
        int           hold_wait;
        int           hold_left;
        bit           hold_done;
        ready_pct    = 100;
        pattern_left = 0;
        hold_wait    = HOLD_DELAY;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.status      = m_status;
                got.found_value = m_found_value;
                got.position    = m_position;
                got.entry_count = m_entry_count;
                mirror.check_reply(got);
            end
            // one long hold-off once random traffic is running
            if (random_phase && !hold_done) begin
                if (hold_wait > 0) begin
                    hold_wait--;
                end else begin
                    hold_left = HOLD_LEN;
                    hold_done = 1'b1;
                end
            end
            if (pattern_left == 0) begin
                case ($urandom_range(3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 40;
                    default: ready_pct = 15;
                endcase
                pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) < ready_pct);
            end
        end
    end

    initial begin : request_source
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] apple;
        logic [KEY_W-1:0] mango;
        logic [KEY_W-1:0] kiwi;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [OP_W-1:0]  op;
        traffic_mode_t    mode;
        int               n;
        int               b;
        int               len;
        int               pick;
        int               burst_left;
        int               full_tries;
        int               empty_tries;
        int               mixed_left;

        mirror = new();
        apple  = {"apple", 24'd0};
        mango  = {"mango", 24'd0};
        kiwi   = {"kiwi", 32'd0};

        // Build a key pool: half short packed names, half raw 64-bit keys
        for (n = 0; n < POOL_SIZE; n++) begin
            if (n % 2 == 0) begin
                len = $urandom_range(1, 8);
                key = '0;
                for (b = 0; b < 8; b++) begin
                    key = {key[KEY_W-9:0], (b < len) ? 8'($urandom_range(97, 122)) : 8'd0};
                end
                key_pool[n] = key;
            end else begin
                key_pool[n] = {$urandom, $urandom};
            end
        end

        // Hold reset, then release
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, no-op, extremes, duplicates, missing keys
        offer_request(OP_FIND, mango, '0);
        offer_request(OP_REMOVE, apple, '0);
        offer_request(OP_UNUSED, '1, '1);
        offer_request(OP_INSERT, mango, {"100", 40'd0});
        pause_sender($urandom_range(3));
        offer_request(OP_INSERT, '0, '1);
        offer_request(OP_INSERT, '1, '0);
        offer_request(OP_INSERT, apple, {"7", 56'd0});
        pause_sender($urandom_range(3));
        offer_request(OP_INSERT, mango, {"200", 40'd0});
        offer_request(OP_FIND, mango, '1);
        offer_request(OP_FIND, '0, '0);
        offer_request(OP_FIND, '1, '0);
        pause_sender($urandom_range(3));
        offer_request(OP_FIND, kiwi, '0);
        offer_request(OP_REMOVE, mango, '0);
        offer_request(OP_FIND, mango, '0);
        offer_request(OP_REMOVE, kiwi, '1);
        offer_request(OP_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
        pause_sender($urandom_range(3));
        offer_request(OP_REMOVE, '0, '0);
        offer_request(OP_REMOVE, '1, '0);
        offer_request(OP_INSERT, apple, '1);
        offer_request(OP_FIND, apple, '0);

        // Random traffic: fill to full, drain to empty, mixed in between
        random_phase = 1'b1;
        mode         = MODE_FILL;
        full_tries   = 0;
        empty_tries  = 0;
        mixed_left   = 0;
        burst_left   = $urandom_range(1, 20);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            case (mode)
                MODE_FILL:
                    op = (pick < 80) ? OP_INSERT : (pick < 88) ? OP_FIND :
                         (pick < 96) ? OP_REMOVE : OP_UNUSED;
                MODE_DRAIN:
                    op = (pick < 10) ? OP_INSERT : (pick < 25) ? OP_FIND :
                         (pick < 96) ? OP_REMOVE : OP_UNUSED;
                default:
                    op = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_FIND :
                         (pick < 97) ? OP_REMOVE : OP_UNUSED;
            endcase

            // Favor live keys on lookups so most find and remove beats hit
            pick = $urandom_range(99);
            if (op != OP_INSERT && mirror.count > 0 && pick < 50) begin
                key = mirror.keys[$urandom_range(mirror.count - 1)];
            end else if (pick < 75) begin
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 92) begin
                key = {$urandom, $urandom};
            end else begin
                key = $urandom_range(1) ? '0 : '1;
            end

            if ($urandom_range(99) < 70) begin
                value = {$urandom, $urandom};
            end else begin
                len   = $urandom_range(1, 8);
                value = '0;
                for (b = 0; b < 8; b++) begin
                    value = {value[VAL_W-9:0], (b < len) ? 8'($urandom_range(48, 57)) : 8'd0};
                end
            end

            offer_request(op, key, value);

            // Advance the traffic mode on table occupancy
            case (mode)
                MODE_FILL: begin
                    if (mirror.count == TABLE_DEPTH) full_tries++;
                    if (full_tries >= 6) begin
                        mode        = MODE_DRAIN;
                        full_tries  = 0;
                    end
                end
                MODE_DRAIN: begin
                    if (mirror.count == 0) empty_tries++;
                    if (empty_tries >= 4) begin
                        mode        = MODE_MIXED;
                        empty_tries = 0;
                        mixed_left  = 60;
                    end
                end
                default: begin
                    mixed_left--;
                    if (mixed_left <= 0) mode = MODE_FILL;
                end
            endcase

            // Bursts of random length separated by random gaps
            burst_left--;
            if (burst_left == 0) begin
                pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 20);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding replies, then let the clock run on before the verdict
        while (mirror.awaited.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
            $display("sorted_key_value_table_core verification clean");
        end else begin
            $display("sorted_key_value_table_core verification failed");
        end
        $finish;
    end

endmodule

@@ sorted_key_value_table_core.f @@
+incdir+rtl/core
rtl/core/skvt_pkg.sv
rtl/core/skvt_cell.sv
rtl/core/sorted_key_value_table_core.sv
tb/sv/sorted_key_value_table_core_tb.sv
